// File: hw/rtl/pud_pkg.sv
// Shared types, character codes and helpers for the form-urlencoded percent decoder.
// No dependencies; the files that use it take names from here by scope.
`default_nettype none

package pud_pkg;

   // character codes
   localparam logic [7:0] PCT_CHAR   = 8'h25;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // escape phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;   // no escape pending
   localparam logic [1:0] PH_PCT   = 2'd1;   // '%' seen
   localparam logic [1:0] PH_DIGIT = 2'd2;   // '%' and one hex digit seen

   // default depth of the bundle queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;

   // decoded bytes that one input word settles, oldest in data[0]
   typedef struct packed {
      logic [1:0]      count;   // 1 to 3 valid bytes
      logic [2:0][7:0] data;
      logic            last;    // final byte of the bundle ends the string
   } pud_bundle_type;

   // front status seen by the top level
   typedef struct packed {
      logic [1:0] phase;
      logic       escape_open;
   } pud_front_status_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nib;
   } pud_hex_type;

   // hex digit of either case to its value
   function automatic pud_hex_type hex_decode(input logic [7:0] c);
      pud_hex_type r;
      r.ok  = 1'b0;
      r.nib = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.ok  = 1'b1;
         r.nib = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r.ok  = 1'b1;
         r.nib = c[3:0] + 4'd9;
      end
      return r;
   endfunction

   // '+' stands for a space
   function automatic logic [7:0] map_plus(input logic [7:0] c);
      return (c == PLUS_CHAR) ? SPACE_CHAR : c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pud_req_if.sv
// Input channel of the percent decoder: one raw byte and an end-of-string flag per word.
// No dependencies.
`default_nettype none

interface pud_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pud_rsp_if.sv
// Result channel of the percent decoder: one decoded byte and an end-of-string flag per word.
// No dependencies.
`default_nettype none

interface pud_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pud_front.sv
// Front end: accepts raw bytes, tracks the escape phase and builds decoded bundles.
// Depends on pud_pkg.
`default_nettype none

module pud_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [7:0]                    in_byte,
   input  wire logic                          in_last,
   output logic                               push,
   input  wire logic                          queue_full,
   output pud_pkg::pud_bundle_type            bundle,
   output pud_pkg::pud_front_status_type      status
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;

   pud_pkg::pud_hex_type cur_hex, held_hex;
   logic       accept;
   logic       p_emit;
   logic [7:0] p_byte;
   logic [1:0] p_phase;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   assign status.phase       = phase_ff;
   assign status.escape_open = (phase_ff != pud_pkg::PH_IDLE);

   // plain-state handling of the current byte
   always_comb begin
      cur_hex  = pud_pkg::hex_decode(in_byte);
      held_hex = pud_pkg::hex_decode(held_ff);
      if (in_byte == pud_pkg::PCT_CHAR) begin
         p_emit  = in_last;
         p_byte  = pud_pkg::PCT_CHAR;
         p_phase = in_last ? pud_pkg::PH_IDLE : pud_pkg::PH_PCT;
      end else begin
         p_emit  = 1'b1;
         p_byte  = pud_pkg::map_plus(in_byte);
         p_phase = pud_pkg::PH_IDLE;
      end
   end

   // bundle and next phase by current phase
   always_comb begin
      bundle.data  = '0;
      bundle.count = 2'd0;
      bundle.last  = in_last;
      phase_in     = phase_ff;
      held_in      = held_ff;
      case (phase_ff)
         pud_pkg::PH_PCT: begin
            if (cur_hex.ok && !in_last) begin
               held_in  = in_byte;
               phase_in = pud_pkg::PH_DIGIT;
            end else begin
               bundle.data[0] = pud_pkg::PCT_CHAR;
               bundle.data[1] = p_byte;
               bundle.count   = 2'd1 + {1'b0, p_emit};
               phase_in       = p_phase;
            end
         end
         pud_pkg::PH_DIGIT: begin
            if (cur_hex.ok && held_hex.ok) begin
               bundle.data[0] = {held_hex.nib, cur_hex.nib};
               bundle.count   = 2'd1;
               phase_in       = pud_pkg::PH_IDLE;
            end else begin
               // bad second digit: '%' and the held digit go out literally
               bundle.data[0] = pud_pkg::PCT_CHAR;
               bundle.data[1] = pud_pkg::map_plus(held_ff);
               bundle.data[2] = p_byte;
               bundle.count   = 2'd2 + {1'b0, p_emit};
               phase_in       = p_phase;
            end
         end
         default: begin
            bundle.data[0] = p_byte;
            bundle.count   = {1'b0, p_emit};
            phase_in       = p_phase;
         end
      endcase
   end

   assign push = accept && (bundle.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pud_pkg::PH_IDLE;
         held_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pud_queue.sv
// Small bundle queue between front and back, flip-flop storage.
// Depends on pud_pkg.
`default_nettype none

module pud_queue #(
   parameter int unsigned DEPTH = pud_pkg::QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire pud_pkg::pud_bundle_type  push_bundle,
   output logic                          full,
   input  wire logic                     pop,
   output logic                          head_valid,
   output pud_pkg::pud_bundle_type       head_bundle
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pud_pkg::pud_bundle_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full        = (count_ff == CNT_W'(DEPTH));
   assign head_valid  = (count_ff != '0);
   assign head_bundle = slots_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pud_back.sv
// Back end: holds one bundle, sends a byte per cycle while out_ready.
// Depends on pud_pkg.
`default_nettype none

module pud_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     head_valid,
   input  wire pud_pkg::pud_bundle_type  head_bundle,
   output logic                          pop,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [7:0]                    out_byte,
   output logic                          out_last
);

   pud_pkg::pud_bundle_type cur_ff;
   logic       valid_ff;
   logic [1:0] idx_ff;
   logic       fire;
   logic       final_byte;

   assign final_byte = (idx_ff == cur_ff.count - 2'd1);
   assign fire       = valid_ff && out_ready;
   assign pop        = head_valid && (!valid_ff || (fire && final_byte));

   assign out_valid = valid_ff;
   assign out_byte  = cur_ff.data[idx_ff];
   assign out_last  = cur_ff.last && final_byte;

   // load the next bundle as soon as the current one is spent
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (pop) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (fire && final_byte) begin
         valid_ff <= 1'b0;
      end else if (fire) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_bundle;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/form_url_percent_decoder.sv
// Top level of the form-urlencoded percent decoder: front, bundle queue and back.
// Depends on pud_pkg, pud_req_if, pud_rsp_if, pud_front, pud_queue, pud_back.
//
//  channel   dir   word                   handshake
//  req_bus   in    in_byte[7:0], in_last  valid/ready, taken when both high
//  rsp_bus   out   out_byte[7:0], out_last valid/ready, taken when both high
//
// One raw byte is accepted per cycle while the queue is not full. Each becomes 0 to
// 3 decoded bytes; the back end sends one per cycle while rsp_bus.ready is high, so
// a 2- or 3-byte bundle holds it while the QUEUE_DEPTH-entry bundle queue keeps the
// front taking bytes. Results are registered in the queue and then in the back end.
// req_bus.ready drops only while the queue is full; rsp stalls back up into the queue.
// Synchronous reset clears the escape phase, the queue pointers and the output stage.
`default_nettype none

module form_url_percent_decoder #(
   parameter int unsigned QUEUE_DEPTH = pud_pkg::QUEUE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pud_req_if.sink    req_bus,
   pud_rsp_if.source  rsp_bus
);

   pud_pkg::pud_bundle_type       push_bundle, head_bundle;
   pud_pkg::pud_front_status_type front_status;
   logic q_push, q_full, q_pop, q_valid;

   pud_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_byte    (req_bus.in_byte),
      .in_last    (req_bus.in_last),
      .push       (q_push),
      .queue_full (q_full),
      .bundle     (push_bundle),
      .status     (front_status)
   );

   pud_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_bundle (push_bundle),
      .full        (q_full),
      .pop         (q_pop),
      .head_valid  (q_valid),
      .head_bundle (head_bundle)
   );

   pud_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_valid),
      .head_bundle (head_bundle),
      .pop         (q_pop),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_byte    (rsp_bus.out_byte),
      .out_last    (rsp_bus.out_last)
   );

   // queue is never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("bundle queue written while full");

   // back end only pops a filled queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("bundle queue popped while empty");

   // end of string always closes any open escape
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.in_last)
      |=> !front_status.escape_open)
      else $error("escape still open after end of string");

endmodule

`default_nettype wire

// File: tb/tb_form_url_percent_decoder.sv
// Self-checking testbench for the form-urlencoded percent decoder.
// Depends on pud_pkg, pud_req_if, pud_rsp_if and form_url_percent_decoder.
`timescale 1ns / 1ps

module tb_form_url_percent_decoder;

   localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 16;    // quiet cycles after the last expected word
   localparam int MAX_REPORTS  = 10;

   // one decoded word as it should leave the block
   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } decoded_word_type;

   logic clock;
   logic reset;

   pud_req_if req_bus ();
   pud_rsp_if rsp_bus ();

   form_url_percent_decoder DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // decoder state mirrored on the testbench side
   logic [1:0]       esc_phase;
   logic [7:0]       held_char;
   decoded_word_type decoded_q[$];

   int mismatch_count;
   int send_idle_pct;
   int recv_stall_pct;

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Decode prediction
   // ---------------------------------------------------------------

   // bit 4 set when c is a hex digit of either case, value in [3:0]
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c >= "0" && c <= "9") begin
         v = c - "0";
         return {1'b1, v[3:0]};
      end
      if (c >= "A" && c <= "F") begin
         v = c - "A" + 8'd10;
         return {1'b1, v[3:0]};
      end
      if (c >= "a" && c <= "f") begin
         v = c - "a" + 8'd10;
         return {1'b1, v[3:0]};
      end
      return 5'd0;
   endfunction

   function automatic void push_decoded(input logic [7:0] data, input logic is_last);
      decoded_word_type w;
      w.data    = data;
      w.is_last = is_last;
      decoded_q.push_back(w);
   endfunction

   // byte seen with no escape pending
   function automatic void decode_plain(input logic [7:0] c, input logic is_last);
      if (c == pud_pkg::PCT_CHAR) begin
         if (is_last) begin
            push_decoded(pud_pkg::PCT_CHAR, 1'b1);
            esc_phase = pud_pkg::PH_IDLE;
         end else begin
            esc_phase = pud_pkg::PH_PCT;
         end
      end else begin
         push_decoded((c == pud_pkg::PLUS_CHAR) ? pud_pkg::SPACE_CHAR : c, is_last);
         esc_phase = pud_pkg::PH_IDLE;
      end
   endfunction

   // expected decoded words for one accepted raw byte
   function automatic void decode_byte(input logic [7:0] c, input logic is_last);
      logic [4:0] cur;
      logic [4:0] hi;
      cur = hex_nibble(c);
      hi  = hex_nibble(held_char);
      case (esc_phase)
         pud_pkg::PH_PCT: begin
            if (cur[4] && !is_last) begin
               held_char = c;
               esc_phase = pud_pkg::PH_DIGIT;
            end else begin
               push_decoded(pud_pkg::PCT_CHAR, 1'b0);
               decode_plain(c, is_last);
            end
         end
         pud_pkg::PH_DIGIT: begin
            if (cur[4] && hi[4]) begin
               push_decoded({hi[3:0], cur[3:0]}, is_last);
               esc_phase = pud_pkg::PH_IDLE;
            end else begin
               // broken escape: '%' and the held digit go out literally
               push_decoded(pud_pkg::PCT_CHAR, 1'b0);
               push_decoded((held_char == pud_pkg::PLUS_CHAR) ? pud_pkg::SPACE_CHAR
                                                              : held_char, 1'b0);
               esc_phase = pud_pkg::PH_IDLE;
               decode_plain(c, is_last);
            end
         end
         default: decode_plain(c, is_last);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------

   // send one raw byte, predict its output once it is taken
   task automatic send_byte(input logic [7:0] c, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= c;
      req_bus.in_last <= is_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      decode_byte(c, is_last);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], i == s.len() - 1);
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   // compare every accepted result word with the oldest prediction
   always @(posedge clock) begin
      decoded_word_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (decoded_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("[%0t] unexpected word: byte %02h last %0b",
                        $realtime, rsp_bus.out_byte, rsp_bus.out_last);
         end else begin
            w = decoded_q.pop_front();
            if (rsp_bus.out_byte !== w.data || rsp_bus.out_last !== w.is_last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("[%0t] mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                           $realtime, w.data, w.is_last, rsp_bus.out_byte, rsp_bus.out_last);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      int quiet_cycles;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   task automatic test_plain_and_plus();
      send_text("a+");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // valid escapes, zero byte, both digit cases
   task automatic test_escapes();
      send_text("%00%Ff");
   endtask

   // bad digit after '%', bad second digit, '%' restarting an escape
   task automatic test_bad_escapes();
      send_text("%g%4z");
      send_text("%%4A");
   endtask

   // string ends with an escape still open
   task automatic test_cut_at_end();
      send_text("%");
      send_text("%4");
      send_text("%+");
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + 8'(n);
      return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
   endfunction

   // strings with valid escapes most common, plain bytes and broken escapes mixed in
   task automatic test_random_strings(input int n_items);
      logic [7:0] text_q[$];
      int         sent;
      int         target_len;
      int         pick;
      logic [7:0] r;
      sent = 0;
      while (sent < n_items) begin
         text_q.delete();
         target_len = $urandom_range(1, 10);
         while (text_q.size() < target_len) begin
            pick = $urandom_range(99);
            r    = 8'($urandom_range(255));
            if (pick < 45) begin
               text_q.push_back(pud_pkg::PCT_CHAR);
               text_q.push_back(hex_char(r[7:4]));
               text_q.push_back(hex_char(r[3:0]));
            end else if (pick < 55) begin
               text_q.push_back(pud_pkg::PLUS_CHAR);
            end else if (pick < 75) begin
               text_q.push_back(r);
            end else if (pick < 85) begin
               text_q.push_back(pud_pkg::PCT_CHAR);
            end else if (pick < 95) begin
               text_q.push_back(pud_pkg::PCT_CHAR);
               text_q.push_back(hex_char(r[3:0]));
               text_q.push_back(8'($urandom_range(255)));
            end else begin
               text_q.push_back(pud_pkg::PCT_CHAR);
               text_q.push_back(r);
            end
         end
         foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
         sent += text_q.size();
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = 8'h00;
      req_bus.in_last = 1'b0;
      rsp_bus.ready   = 1'b0;
      esc_phase       = pud_pkg::PH_IDLE;
      held_char       = 8'h00;
      mismatch_count  = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_plain_and_plus();
      test_escapes();
      test_bad_escapes();
      test_cut_at_end();

      // no idling
      test_random_strings(24);
      // sender often idle
      send_idle_pct  = 67;
      recv_stall_pct = 0;
      test_random_strings(24);
      // receiver often stalled
      send_idle_pct  = 0;
      recv_stall_pct = 67;
      test_random_strings(24);
      // light idling on both sides
      send_idle_pct  = 7;
      recv_stall_pct = 7;
      test_random_strings(24);

      // let every predicted word come out, then watch for strays
      req_bus.valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && decoded_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
